// ----- rtl/pc98pe_pkg.sv -----
`timescale 1ns / 1ps

package pc98pe_pkg;

    localparam int SECTOR_BYTES_DEF = 512;
    localparam int LABEL_BYTES_DEF  = 16;
    localparam int ENTRY_BYTES      = 32;
    localparam int LABEL_MAX        = 16;
    localparam int LOC_OFFSET       = 4;
    localparam int LABEL_OFFSET     = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_WIDTH        = 48;

    localparam logic [8:0] GEOM_MAX   = 9'd256;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [8:0]  HEADS_RESET   = 9'd8;
    localparam logic [8:0]  SECTORS_RESET = 9'd17;
    localparam logic [47:0] DISK_RESET    = 48'd0;
    localparam logic [4:0]  LIMIT_RESET   = 5'd16;

    typedef enum logic [1:0] {
        REG_HEADS,
        REG_SECTORS,
        REG_DISK_BLOCKS,
        REG_ENTRY_LIMIT
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_EMPTY,
        ST_VALID,
        ST_REJECTED,
        ST_GEOM_ZERO
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL_A,
        B_MUL_B,
        B_CHECK
    } back_state_t;

    typedef struct packed {
        logic [8:0]  heads;
        logic [8:0]  sectors;
        logic [47:0] disk_blocks;
        logic [4:0]  entry_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0] cyl;
        logic [7:0]  hd;
        logic [7:0]  sec;
    } loc_t;

    typedef struct packed {
        logic [3:0]                 index;
        logic                       last;
        logic                       empty;
        logic                       boot;
        loc_t [2:0]                 locs;
        logic [4:0]                 label_len;
        logic [LABEL_MAX-1:0][7:0]  label;
    } entry_rec_t;

    typedef struct packed {
        logic [3:0]  entry_index;
        status_t     status;
        logic [31:0] start_block;
        logic [31:0] data_block;
        logic [32:0] block_count;
        logic        bootable;
        logic        has_label;
        logic [4:0]  label_length;
        logic [63:0] label_head;
        logic [63:0] label_tail;
        logic        last_entry;
    } result_t;

endpackage

// ----- rtl/pc98pe_if.sv -----
`timescale 1ns / 1ps

interface pc98pe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface pc98pe_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  entry_index;
    logic [1:0]  status;
    logic [31:0] start_block;
    logic [31:0] data_block;
    logic [32:0] block_count;
    logic        bootable;
    logic        has_label;
    logic [4:0]  label_length;
    logic [63:0] label_head;
    logic [63:0] label_tail;
    logic        last_entry;

    modport source (
        output valid, output entry_index, output status, output start_block,
        output data_block, output block_count, output bootable, output has_label,
        output label_length, output label_head, output label_tail, output last_entry,
        input ready
    );
    modport sink (
        input valid, input entry_index, input status, input start_block,
        input data_block, input block_count, input bootable, input has_label,
        input label_length, input label_head, input label_tail, input last_entry,
        output ready
    );
endinterface

// ----- rtl/pc98_partition_entry_parser.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload                                    Request
// sector    in   data_byte                                  one sector byte
// result    out  entry_index, status, blocks, label fields  one table entry
// wr_*      in   wr_index, wr_data                          register write
//
// Takes one byte per cycle; one result per 32 bytes for entries within the limit.
// Back end per entry: IDLE loads it, a MUL_A/MUL_B pair per location computes its block, CHECK builds the result.
// Input stalls only on an entry's last byte while both queue slots are full.
// Reset loads the register defaults and restarts at sector byte 0; no clearing pass.

module pc98_partition_entry_parser #(
    parameter int SECTOR_BYTES = pc98pe_pkg::SECTOR_BYTES_DEF,
    parameter int LABEL_BYTES  = pc98pe_pkg::LABEL_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pc98pe_byte_if.sink                         sector,
    pc98pe_result_if.source                     result,
    input  logic                                wr_en,
    input  pc98pe_pkg::cfg_index_t              wr_index,
    input  logic [pc98pe_pkg::CFG_WIDTH-1:0]    wr_data
);
    import pc98pe_pkg::*;

    cfg_t        cfg_reg;
    logic [8:0]  geom_value;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    entry_rec_t  q_in;
    entry_rec_t  q_head;

    assign geom_value = (wr_data[8:0] > GEOM_MAX) ? GEOM_MAX : wr_data[8:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heads       <= HEADS_RESET;
            cfg_reg.sectors     <= SECTORS_RESET;
            cfg_reg.disk_blocks <= DISK_RESET;
            cfg_reg.entry_limit <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HEADS:       cfg_reg.heads       <= geom_value;
                REG_SECTORS:     cfg_reg.sectors     <= geom_value;
                REG_DISK_BLOCKS: cfg_reg.disk_blocks <= wr_data[47:0];
                REG_ENTRY_LIMIT: cfg_reg.entry_limit <= wr_data[4:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    pc98pe_front #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .LABEL_BYTES  (LABEL_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sector      (sector),
        .entry_limit (cfg_reg.entry_limit),
        .q_full      (q_full),
        .push        (q_push),
        .push_rec    (q_in)
    );

    pc98pe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    pc98pe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .result  (result)
    );

endmodule

// ----- rtl/pc98pe_queue.sv -----
`timescale 1ns / 1ps

module pc98pe_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pc98pe_pkg::entry_rec_t  push_rec,
    output logic                    full,
    input  logic                    pop,
    output pc98pe_pkg::entry_rec_t  head,
    output logic                    empty
);
    import pc98pe_pkg::*;

    localparam int PTW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTW-1:0] PTR_LAST = PTW'(QUEUE_DEPTH - 1);
    localparam logic [CNW-1:0] CNT_FULL = CNW'(QUEUE_DEPTH);

    entry_rec_t           slot_reg [QUEUE_DEPTH];
    logic [PTW-1:0]       wr_ptr_reg;
    logic [PTW-1:0]       wr_ptr_next;
    logic [PTW-1:0]       rd_ptr_reg;
    logic [PTW-1:0]       rd_ptr_next;
    logic [CNW-1:0]       count_reg;
    logic [CNW-1:0]       count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTW'(1);
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + CNW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/pc98pe_front.sv -----
`timescale 1ns / 1ps

module pc98pe_front #(
    parameter int SECTOR_BYTES = pc98pe_pkg::SECTOR_BYTES_DEF,
    parameter int LABEL_BYTES  = pc98pe_pkg::LABEL_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    pc98pe_byte_if.sink             sector,
    input  logic [4:0]              entry_limit,
    input  logic                    q_full,
    output logic                    push,
    output pc98pe_pkg::entry_rec_t  push_rec
);
    import pc98pe_pkg::*;

    localparam int PW    = $clog2(SECTOR_BYTES);
    localparam int OW    = $clog2(ENTRY_BYTES);
    localparam int EW    = PW - OW;
    localparam int CW    = (EW + 1 > 5) ? EW + 1 : 5;
    localparam int TOTAL = SECTOR_BYTES / ENTRY_BYTES;
    localparam int LIW   = $clog2(LABEL_MAX);
    localparam logic [PW-1:0] POS_LAST  = PW'(SECTOR_BYTES - 1);
    localparam logic [OW-1:0] OFF_LAST  = OW'(ENTRY_BYTES - 1);
    localparam logic [OW:0]   LOC_LO    = (OW + 1)'(LOC_OFFSET);
    localparam logic [OW:0]   LOC_HI    = (OW + 1)'(LOC_OFFSET + 12);
    localparam logic [OW:0]   LABEL_LO  = (OW + 1)'(LABEL_OFFSET);
    localparam logic [OW:0]   LABEL_HI  = (OW + 1)'(LABEL_OFFSET + LABEL_BYTES);
    localparam logic [CW-1:0] TOTAL_EXT = CW'(TOTAL);

    logic [PW-1:0]              pos_reg;
    logic [4:0]                 count_reg;
    logic [4:0]                 count_next;
    logic                       stopped_reg;
    logic                       stopped_next;
    logic [LABEL_MAX-1:0][7:0]  label_reg;
    logic [LABEL_MAX-1:0][7:0]  label_next;
    logic [7:0]                 mark0_reg;
    logic [7:0]                 mark1_reg;
    logic [11:0][7:0]           loc_bytes_reg;

    logic [OW-1:0] off;
    logic [OW:0]   off_ext;
    logic [CW-1:0] entry_ext;
    logic [CW-1:0] limit_ext;
    logic          emit;
    logic          accept;
    logic          in_label;
    logic [3:0]    loc_sel;

    assign off       = pos_reg[OW-1:0];
    assign off_ext   = {1'b0, off};
    assign entry_ext = CW'(pos_reg[PW-1:OW]);
    assign limit_ext = (CW'(entry_limit) < TOTAL_EXT) ? CW'(entry_limit) : TOTAL_EXT;
    assign emit      = (off == OFF_LAST) && (entry_ext < limit_ext);
    assign sector.ready = !(emit && q_full);
    assign accept    = sector.valid && sector.ready;
    assign push      = accept && emit;
    assign in_label  = (off_ext >= LABEL_LO) && (off_ext < LABEL_HI);
    assign loc_sel   = 4'(off_ext - LOC_LO);

    always_comb
    begin
        label_next   = label_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        if (off == '0)
        begin
            label_next   = '0;
            count_next   = '0;
            stopped_next = 1'b0;
        end
        if (in_label && !stopped_reg)
        begin
            if (sector.data_byte == CHAR_NUL || sector.data_byte == CHAR_SPACE)
            begin
                stopped_next = 1'b1;
            end
            else if (count_reg < 5'(LABEL_MAX))
            begin
                label_next[count_reg[LIW-1:0]] = sector.data_byte;
                count_next = count_reg + 5'd1;
            end
        end
    end

    always_comb
    begin
        push_rec           = '0;
        push_rec.index     = entry_ext[3:0];
        push_rec.last      = (entry_ext + CW'(1)) == limit_ext;
        push_rec.empty     = (mark0_reg == 8'h00);
        push_rec.boot      = mark0_reg[7] && mark1_reg[7];
        push_rec.label_len = count_next;
        push_rec.label     = label_next;
        for (int i = 0; i < 3; i++)
        begin
            push_rec.locs[i].sec = loc_bytes_reg[4 * i];
            push_rec.locs[i].hd  = loc_bytes_reg[4 * i + 1];
            push_rec.locs[i].cyl = {loc_bytes_reg[4 * i + 3], loc_bytes_reg[4 * i + 2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            label_reg <= label_next;
            if (off == '0)
            begin
                mark0_reg <= sector.data_byte;
            end
            if (off == OW'(1))
            begin
                mark1_reg <= sector.data_byte;
            end
            if (off_ext >= LOC_LO && off_ext < LOC_HI)
            begin
                loc_bytes_reg[loc_sel] <= sector.data_byte;
            end
        end
    end

endmodule

// ----- rtl/pc98pe_back.sv -----
`timescale 1ns / 1ps

module pc98pe_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pc98pe_pkg::cfg_t        cfg,
    input  pc98pe_pkg::entry_rec_t  head,
    input  logic                    q_empty,
    output logic                    pop,
    pc98pe_result_if.source         result
);
    import pc98pe_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [1:0]        idx_reg;
    entry_rec_t        work_reg;
    logic [23:0]       part_reg;
    logic [2:0][31:0]  blk_reg;
    logic [2:0]        ok_reg;
    result_t           out_reg;
    result_t           res_next;
    logic              out_valid_reg;
    logic              load_out;
    loc_t              cur;
    logic              geom_zero;
    logic [31:0]       start_blk;
    logic [31:0]       data_blk;
    logic [31:0]       end_blk;

    assign cur       = work_reg.locs[idx_reg];
    assign geom_zero = (cfg.heads == '0) || (cfg.sectors == '0);
    assign start_blk = blk_reg[0];
    assign data_blk  = blk_reg[1];
    assign end_blk   = blk_reg[2];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_MUL_A;
                end
            end
            B_MUL_A:
            begin
                state_next = B_MUL_B;
            end
            B_MUL_B:
            begin
                state_next = (idx_reg == 2'd2) ? B_CHECK : B_MUL_A;
            end
            B_CHECK:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == B_IDLE) && !q_empty;
        load_out = (state_reg == B_CHECK) && (!out_valid_reg || result.ready);
    end

    always_comb
    begin
        res_next             = '0;
        res_next.entry_index = work_reg.index;
        res_next.last_entry  = work_reg.last;
        priority if (geom_zero)
        begin
            res_next.status = ST_GEOM_ZERO;
        end
        else if (work_reg.empty)
        begin
            res_next.status = ST_EMPTY;
        end
        else if (!(&ok_reg) || data_blk < start_blk || end_blk < data_blk
                 || {16'h0000, end_blk} >= cfg.disk_blocks)
        begin
            res_next.status = ST_REJECTED;
        end
        else
        begin
            res_next.status       = ST_VALID;
            res_next.start_block  = start_blk;
            res_next.data_block   = data_blk;
            res_next.block_count  = 33'(end_blk) - 33'(data_blk) + 33'd1;
            res_next.bootable     = work_reg.boot;
            res_next.has_label    = (work_reg.label_len != '0);
            res_next.label_length = work_reg.label_len;
            res_next.label_head   = work_reg.label[7:0];
            res_next.label_tail   = work_reg.label[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == B_MUL_B)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head;
        end
        if (state_reg == B_MUL_A)
        begin
            part_reg <= 24'(25'(cur.cyl) * 25'(cfg.heads) + 25'(cur.hd));
            ok_reg[idx_reg] <= ({1'b0, cur.hd} < cfg.heads) && ({1'b0, cur.sec} < cfg.sectors);
        end
        if (state_reg == B_MUL_B)
        begin
            blk_reg[idx_reg] <= 32'(33'(part_reg) * 33'(cfg.sectors) + 33'(cur.sec));
        end
        if (load_out)
        begin
            out_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.entry_index  = out_reg.entry_index;
    assign result.status       = out_reg.status;
    assign result.start_block  = out_reg.start_block;
    assign result.data_block   = out_reg.data_block;
    assign result.block_count  = out_reg.block_count;
    assign result.bootable     = out_reg.bootable;
    assign result.has_label    = out_reg.has_label;
    assign result.label_length = out_reg.label_length;
    assign result.label_head   = out_reg.label_head;
    assign result.label_tail   = out_reg.label_tail;
    assign result.last_entry   = out_reg.last_entry;

`ifndef SYNTH
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_VALID |-> out_reg.block_count != '0)
        else $error("valid entry with zero block count");

    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_VALID |->
            out_reg.block_count == '0 && !out_reg.bootable && out_reg.label_length == '0)
        else $error("non-valid entry carries data");

    a_hold_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CHECK && out_valid_reg && !result.ready |=> state_reg == B_CHECK)
        else $error("result dropped while output stalled");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pc98pe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_BYTES  = 320;
    localparam int RANDOM_RESULTS = 8;
    localparam int HOLD_OFF      = 400;
    localparam int PRINT_CAP     = 40;

    typedef logic [ENTRY_BYTES-1:0][7:0] entry_t;
    typedef logic [LABEL_MAX-1:0][7:0]   label_t;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    cfg_index_t           wr_index;
    logic [CFG_WIDTH-1:0] wr_data;

    pc98pe_byte_if   sector_if ();
    pc98pe_result_if result_if ();

    pc98_partition_entry_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sector   (sector_if),
        .result   (result_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Parser model state
    cfg_t                cur_cfg = '{HEADS_RESET, SECTORS_RESET, DISK_RESET, LIMIT_RESET};
    int unsigned         tbl_pos = 0;
    logic [1:0][7:0]     entry_marks = '0;
    logic [11:0][7:0]    entry_locs = '0;
    label_t              label_chars = '0;
    int unsigned         label_len = 0;
    bit                  label_done = 1'b0;
    result_t             expected_entries[$];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  status_hits[4] = '{0, 0, 0, 0};
    int  sent_bytes = 0;
    int  reg_writes = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    int  hold_cycles = 0;
    int  sink_burst = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result-side ready: long hold-off while hold_cycles is set, else random stall bursts while idle_on is set
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_if.ready <= 1'b0;
                hold_cycles--;
            end
            else if (sink_burst > 0)
            begin
                result_if.ready <= 1'b0;
                sink_burst--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                sink_burst = $urandom_range(0, 4);
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic bit loc_block(int base, output logic [63:0] blk);
        logic [63:0] sec;
        logic [63:0] hd;
        logic [63:0] cyl;
        sec = 64'(entry_locs[base]);
        hd  = 64'(entry_locs[base + 1]);
        cyl = 64'({entry_locs[base + 3], entry_locs[base + 2]});
        blk = '0;
        if (hd >= 64'(cur_cfg.heads) || sec >= 64'(cur_cfg.sectors))
            return 1'b0;
        blk = (cyl * 64'(cur_cfg.heads) + hd) * 64'(cur_cfg.sectors) + sec;
        return 1'b1;
    endfunction

    task automatic take_sector_byte(logic [7:0] b);
        int unsigned off;
        int unsigned ent;
        int unsigned lim;
        logic [63:0] s_blk;
        logic [63:0] d_blk;
        logic [63:0] e_blk;
        result_t     r;
        off = tbl_pos % ENTRY_BYTES;
        ent = tbl_pos / ENTRY_BYTES;
        tbl_pos = (tbl_pos + 1 >= SECTOR_BYTES_DEF) ? 0 : tbl_pos + 1;
        if (off == 0)
        begin
            label_chars = '0;
            label_len = 0;
            label_done = 1'b0;
        end
        if (off < 2)
            entry_marks[off] = b;
        else if (off >= LOC_OFFSET && off < LOC_OFFSET + 12)
            entry_locs[off - LOC_OFFSET] = b;
        else if (off >= LABEL_OFFSET && off < LABEL_OFFSET + LABEL_BYTES_DEF && !label_done)
        begin
            if (b == CHAR_NUL || b == CHAR_SPACE)
                label_done = 1'b1;
            else if (label_len < LABEL_MAX)
            begin
                label_chars[label_len] = b;
                label_len++;
            end
        end
        if (off != ENTRY_BYTES - 1)
            return;
        lim = SECTOR_BYTES_DEF / ENTRY_BYTES;
        if (cur_cfg.entry_limit < lim)
            lim = cur_cfg.entry_limit;
        if (ent >= lim)
            return;
        r = '0;
        r.entry_index = ent[3:0];
        r.last_entry = (ent + 1 == lim);
        if (cur_cfg.heads == 0 || cur_cfg.sectors == 0)
            r.status = ST_GEOM_ZERO;
        else if (entry_marks[0] == 8'h00)
            r.status = ST_EMPTY;
        else if (!loc_block(0, s_blk) || !loc_block(4, d_blk) || !loc_block(8, e_blk) ||
                 d_blk < s_blk || e_blk < d_blk || e_blk >= 64'(cur_cfg.disk_blocks))
            r.status = ST_REJECTED;
        else
        begin
            r.status = ST_VALID;
            r.start_block = s_blk[31:0];
            r.data_block = d_blk[31:0];
            r.block_count = 33'(e_blk - d_blk + 64'd1);
            r.bootable = entry_marks[0][7] && entry_marks[1][7];
            r.has_label = (label_len != 0);
            r.label_length = label_len[4:0];
            r.label_head = label_chars[7:0];
            r.label_tail = label_chars[15:8];
        end
        expected_entries.push_back(r);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want, int ent);
        if (got !== want)
            report_mismatch($sformatf("entry %0d %s: got %0h, expected %0h",
                                      ent, name, got, want));
    endtask

    task automatic check_result();
        result_t want;
        int      ent;
        if (expected_entries.size() == 0)
        begin
            report_mismatch($sformatf("result for entry %0d with no request pending",
                                      result_if.entry_index));
            return;
        end
        want = expected_entries.pop_front();
        ent = want.entry_index;
        results_checked++;
        status_hits[int'(want.status)]++;
        check_field("entry_index", result_if.entry_index, want.entry_index, ent);
        check_field("status", result_if.status, want.status, ent);
        check_field("start_block", result_if.start_block, want.start_block, ent);
        check_field("data_block", result_if.data_block, want.data_block, ent);
        check_field("block_count", result_if.block_count, want.block_count, ent);
        check_field("bootable", result_if.bootable, want.bootable, ent);
        check_field("has_label", result_if.has_label, want.has_label, ent);
        check_field("label_length", result_if.label_length, want.label_length, ent);
        check_field("label_head", result_if.label_head, want.label_head, ent);
        check_field("label_tail", result_if.label_tail, want.label_tail, ent);
        check_field("last_entry", result_if.last_entry, want.last_entry, ent);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sector_if.valid && sector_if.ready)
                take_sector_byte(sector_if.data_byte);
            if (result_if.valid && result_if.ready)
                check_result();
        end
    end

    task automatic send_byte(logic [7:0] b);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sector_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        sector_if.valid <= 1'b1;
        sector_if.data_byte <= b;
        do
            @(posedge clk);
        while (!sector_if.ready);
        sent_bytes++;
    endtask

    task automatic send_entry(entry_t e);
        for (int k = 0; k < ENTRY_BYTES; k++)
            send_byte(e[k]);
    endtask

    // Drop valid, then wait out every pending result and the back end
    task automatic wait_drain();
        @(negedge clk);
        sector_if.valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_WIDTH-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_HEADS:       cur_cfg.heads = (val[8:0] > GEOM_MAX) ? GEOM_MAX : val[8:0];
            REG_SECTORS:     cur_cfg.sectors = (val[8:0] > GEOM_MAX) ? GEOM_MAX : val[8:0];
            REG_DISK_BLOCKS: cur_cfg.disk_blocks = val;
            REG_ENTRY_LIMIT: cur_cfg.entry_limit = val[4:0];
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_config(logic [8:0] h, logic [8:0] s, logic [47:0] d, logic [4:0] lim);
        write_reg(REG_HEADS, 48'(h));
        write_reg(REG_SECTORS, 48'(s));
        write_reg(REG_DISK_BLOCKS, d);
        write_reg(REG_ENTRY_LIMIT, 48'(lim));
    endtask

    function automatic loc_t chs(int unsigned cyl, int unsigned hd, int unsigned sec);
        loc_t l;
        l.cyl = cyl[15:0];
        l.hd = hd[7:0];
        l.sec = sec[7:0];
        return l;
    endfunction

    function automatic loc_t block_to_loc(logic [63:0] blk);
        logic [63:0] per_cyl;
        logic [63:0] rem;
        per_cyl = 64'(cur_cfg.heads) * 64'(cur_cfg.sectors);
        rem = blk % per_cyl;
        return chs(32'(blk / per_cyl), 32'(rem / 64'(cur_cfg.sectors)),
                   32'(rem % 64'(cur_cfg.sectors)));
    endfunction

    function automatic label_t text_label(string s, logic [7:0] pad);
        label_t lab;
        for (int i = 0; i < LABEL_MAX; i++)
            lab[i] = (i < s.len()) ? s[i] : pad;
        return lab;
    endfunction

    function automatic entry_t make_entry(logic [7:0] m0, logic [7:0] m1, loc_t start_loc,
                                          loc_t data_loc, loc_t end_loc, label_t lab);
        entry_t e;
        loc_t   trio[3];
        trio[0] = start_loc;
        trio[1] = data_loc;
        trio[2] = end_loc;
        e[0] = m0;
        e[1] = m1;
        e[2] = 8'($urandom);
        e[3] = 8'($urandom);
        for (int i = 0; i < 3; i++)
        begin
            e[LOC_OFFSET + 4 * i]     = trio[i].sec;
            e[LOC_OFFSET + 4 * i + 1] = trio[i].hd;
            e[LOC_OFFSET + 4 * i + 2] = trio[i].cyl[7:0];
            e[LOC_OFFSET + 4 * i + 3] = trio[i].cyl[15:8];
        end
        for (int i = 0; i < LABEL_MAX; i++)
            e[LABEL_OFFSET + i] = lab[i];
        return e;
    endfunction

    function automatic label_t random_label();
        label_t      lab;
        int unsigned len;
        lab = {$urandom, $urandom, $urandom, $urandom};
        len = ($urandom_range(0, 3) == 0) ? LABEL_MAX : $urandom_range(0, LABEL_MAX);
        for (int i = 0; i < len; i++)
            do
                lab[i] = 8'($urandom_range(1, 255));
            while (lab[i] == CHAR_SPACE);
        if (len < LABEL_MAX)
            lab[len] = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_NUL;
        return lab;
    endfunction

    function automatic entry_t noise_entry();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic entry_t random_good_entry();
        logic [63:0] cap;
        logic [63:0] hi;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] t;
        cap = 64'(cur_cfg.heads) * 64'(cur_cfg.sectors) * 64'd65536;
        hi = (cur_cfg.disk_blocks != 0 && 64'(cur_cfg.disk_blocks) < cap) ?
             64'(cur_cfg.disk_blocks) : cap;
        a = {$urandom, $urandom} % hi;
        b = {$urandom, $urandom} % hi;
        c = ($urandom_range(0, 2) == 0) ? a + ({$urandom, $urandom} % 64) : {$urandom, $urandom} % hi;
        if (c >= hi)
            c = hi - 1;
        case ($urandom_range(0, 5))
            0: a = 0;
            1: c = hi - 1;
            2: b = a;
            default: ;
        endcase
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        return make_entry(8'($urandom_range(1, 255)), 8'($urandom), block_to_loc(a),
                          block_to_loc(b), block_to_loc(c), random_label());
    endfunction

    function automatic entry_t random_broken_entry();
        entry_t      e;
        int unsigned which;
        logic [31:0] held;
        e = random_good_entry();
        which = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
            0: if (cur_cfg.heads < GEOM_MAX)
                e[LOC_OFFSET + 4 * which + 1] = 8'($urandom_range(cur_cfg.heads, 255));
            1: if (cur_cfg.sectors < GEOM_MAX)
                e[LOC_OFFSET + 4 * which] = 8'($urandom_range(cur_cfg.sectors, 255));
            2:
            begin
                held = e[LOC_OFFSET + 3:LOC_OFFSET];
                e[LOC_OFFSET + 3:LOC_OFFSET] = e[LOC_OFFSET + 11:LOC_OFFSET + 8];
                e[LOC_OFFSET + 11:LOC_OFFSET + 8] = held;
            end
            default:
            begin
                e[LOC_OFFSET + 8]  = 8'(cur_cfg.sectors - 1);
                e[LOC_OFFSET + 9]  = 8'(cur_cfg.heads - 1);
                e[LOC_OFFSET + 10] = 8'hFF;
                e[LOC_OFFSET + 11] = 8'hFF;
            end
        endcase
        return e;
    endfunction

    function automatic entry_t random_entry();
        entry_t      e;
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (cur_cfg.heads == 0 || cur_cfg.sectors == 0 || kind >= 17)
        begin
            e = noise_entry();
            if (kind == 19)
                e[0] = 8'h00;
        end
        else if (kind >= 14)
            e = random_broken_entry();
        else
            e = random_good_entry();
        return e;
    endfunction

    function automatic logic [8:0] random_geometry();
        case ($urandom_range(0, 19))
            0:       return 9'd0;
            1:       return 9'($urandom_range(256, 511));
            2, 3, 4: return 9'($urandom_range(128, 255));
            default: return 9'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic pick_random_setup();
        logic [8:0]  h;
        logic [8:0]  s;
        logic [63:0] cap;
        logic [47:0] d;
        logic [4:0]  lim;
        h = random_geometry();
        s = random_geometry();
        cap = 64'((h > GEOM_MAX) ? GEOM_MAX : h) * 64'((s > GEOM_MAX) ? GEOM_MAX : s) * 64'd65536;
        case ($urandom_range(0, 9))
            0:       d = '1;
            1:       d = 48'({$urandom, $urandom});
            2:       d = 48'($urandom_range(0, 2000));
            default: d = 48'(cap / 2 + ({$urandom, $urandom} % (cap / 2 + 1)));
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: lim = 5'd16;
            3:       lim = 5'($urandom_range(17, 31));
            4:       lim = 5'($urandom_range(0, 3));
            default: lim = 5'($urandom_range(4, 15));
        endcase
        set_config(h, s, d, lim);
    endtask

    task automatic run_random_phase(int entries);
        pick_random_setup();
        repeat (entries) send_entry(random_entry());
        wait_drain();
    endtask

    task automatic test_reset_defaults();
        send_entry(make_entry(8'h00, 8'h00, chs(0, 0, 0), chs(0, 0, 0), chs(0, 0, 0),
                              text_label("", CHAR_NUL)));
        send_entry(make_entry(8'h81, 8'h00, chs(0, 0, 0), chs(0, 0, 1), chs(2, 7, 16),
                              text_label("BOOT", CHAR_NUL)));
        wait_drain();
    endtask

    task automatic test_directed_entries();
        label_t lab;
        set_config(9'd16, 9'd63, 48'd1_000_000, 5'd16);
        send_entry(make_entry(8'h80, 8'h80, chs(1, 0, 0), chs(1, 0, 1), chs(10, 15, 62),
                              text_label("SYSTEM", CHAR_SPACE)));
        send_entry(make_entry(8'h80, 8'h00, chs(0, 0, 0), chs(0, 0, 0), chs(0, 0, 5),
                              text_label("ABCDEFGHIJKLMNOP", CHAR_NUL)));
        lab = '0;
        lab[1] = 8'h5A;
        send_entry(make_entry(8'h01, 8'hFF, chs(0, 0, 0), chs(0, 0, 0), chs(0, 0, 5), lab));
        send_entry(make_entry(8'h00, 8'h80, chs(0, 0, 0), chs(0, 0, 1), chs(0, 0, 2),
                              text_label("NOTSHOWN", CHAR_NUL)));
        send_entry(make_entry(8'h40, 8'h00, chs(0, 16, 0), chs(1, 0, 0), chs(2, 0, 0),
                              text_label("HEAD", CHAR_NUL)));
        send_entry(make_entry(8'h40, 8'h00, chs(0, 0, 0), chs(1, 0, 0), chs(2, 0, 63),
                              text_label("SECT", CHAR_NUL)));
        send_entry(make_entry(8'h40, 8'h00, chs(5, 0, 0), chs(4, 0, 0), chs(6, 0, 0),
                              text_label("ORDER", CHAR_NUL)));
        send_entry(make_entry(8'h40, 8'h00, chs(1, 0, 0), chs(3, 0, 0), chs(2, 0, 0),
                              text_label("ORDER", CHAR_NUL)));
        send_entry(make_entry(8'h40, 8'h00, chs(0, 0, 0), chs(0, 0, 1), chs(992, 1, 0),
                              text_label("EDGE", CHAR_NUL)));
        send_entry(make_entry(8'h40, 8'h00, chs(0, 0, 0), chs(0, 0, 1), chs(992, 1, 1),
                              text_label("PAST", CHAR_NUL)));
        lab = '1;
        lab[15] = CHAR_SPACE;
        send_entry(make_entry(8'hFE, 8'h7F, chs(7, 3, 9), chs(7, 3, 9), chs(7, 3, 9), lab));
        send_entry(make_entry(8'h7F, 8'h80, chs(2, 2, 2), chs(3, 3, 3), chs(4, 4, 4),
                              text_label("a b", CHAR_NUL)));
        lab = '0;
        lab[0] = 8'h01;
        lab[1] = 8'h7E;
        lab[2] = 8'h80;
        lab[3] = 8'hFE;
        send_entry(make_entry(8'hFF, 8'hFF, chs(0, 0, 0), chs(256, 0, 0), chs(991, 15, 62), lab));
        send_entry(random_good_entry());
        wait_drain();
    endtask

    task automatic test_geometry_limits();
        set_config(9'd0, 9'd63, 48'd1_000_000, 5'd16);
        send_entry(make_entry(8'h00, 8'h00, chs(0, 0, 0), chs(0, 0, 0), chs(0, 0, 0),
                              text_label("", CHAR_NUL)));
        send_entry(make_entry(8'h80, 8'h80, chs(0, 0, 0), chs(0, 0, 1), chs(1, 0, 0),
                              text_label("ZERO", CHAR_NUL)));
        wait_drain();
        write_reg(REG_HEADS, 48'd8);
        write_reg(REG_SECTORS, 48'd0);
        send_entry(make_entry(8'h80, 8'h80, chs(0, 0, 0), chs(0, 0, 1), chs(1, 0, 0),
                              text_label("ZERO", CHAR_NUL)));
        wait_drain();
        set_config(9'd511, 9'd300, '1, 5'd16);
        send_entry(make_entry(8'hFF, 8'h80, chs(0, 0, 0), chs(0, 0, 0), chs(65535, 255, 255),
                              text_label("WHOLEDISKLABEL16", CHAR_NUL)));
        send_entry(make_entry(8'h80, 8'hFF, chs(65535, 255, 255), chs(65535, 255, 255),
                              chs(65535, 255, 255), text_label("TOP", CHAR_SPACE)));
        wait_drain();
        set_config(9'd1, 9'd1, 48'd70000, 5'd16);
        send_entry(make_entry(8'h10, 8'h00, chs(0, 0, 0), chs(100, 0, 0), chs(65535, 0, 0),
                              text_label("ONE", CHAR_NUL)));
        send_entry(make_entry(8'h10, 8'h00, chs(0, 0, 0), chs(5, 1, 0), chs(6, 0, 0),
                              text_label("ONE", CHAR_NUL)));
        wait_drain();
        write_reg(REG_DISK_BLOCKS, 48'd0);
        send_entry(make_entry(8'h10, 8'h00, chs(0, 0, 0), chs(0, 0, 0), chs(0, 0, 0),
                              text_label("NONE", CHAR_NUL)));
        wait_drain();
    endtask

    task automatic test_entry_limit();
        set_config(9'd16, 9'd63, 48'd1_000_000, 5'd0);
        repeat (8) send_entry(random_good_entry());
        wait_drain();
        write_reg(REG_ENTRY_LIMIT, 48'd2);
        repeat (4) send_entry(random_good_entry());
        wait_drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_ENTRY_LIMIT, 48'd16);
        // hold results back while bytes keep coming, so the input stalls
        hold_cycles = HOLD_OFF;
        repeat (6) send_entry(random_good_entry());
        wait_drain();
    endtask

    task automatic test_random_tables();
        int start_bytes;
        int start_results;
        start_bytes = sent_bytes;
        start_results = results_checked;
        while (sent_bytes - start_bytes < RANDOM_BYTES ||
               results_checked - start_results < RANDOM_RESULTS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            run_random_phase($urandom_range(4, 8));
        end
    endtask

    task automatic test_quiet_finish();
        idle_on = 1'b0;
        run_random_phase(8);
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_HEADS;
        wr_data = '0;
        sector_if.valid = 1'b0;
        sector_if.data_byte = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_entries();
        test_geometry_limits();
        test_entry_limit();
        test_backpressure();
        test_random_tables();
        test_quiet_finish();

        $display("Sent %0d table bytes with %0d register writes; checked %0d entry results.",
                 sent_bytes, reg_writes, results_checked);
        $display("Statuses seen: empty %0d, valid %0d, rejected %0d, zero geometry %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
